>>> hw/rtl/tcg_pkg.sv
// Shared types, codes and helper functions for the tile candidate grid.
// No dependencies; used by tile_candidate_grid_core.
package tcg_pkg;

	localparam int CELL_W    = 32;   // candidate mask width
	localparam int CNT_W     = 6;    // candidate count, 0..32
	localparam int CFG_W     = 32;   // configuration data width
	localparam int CFG_AW    = 4;    // configuration byte address width

	localparam int MAX_ROWS_DEF  = 16;
	localparam int MAX_COLS_DEF  = 16;
	localparam int MAX_TILES_DEF = 32;

	localparam logic [4:0] ROWS_RST  = 5'd16;
	localparam logic [4:0] COLS_RST  = 5'd16;
	localparam logic [5:0] TILES_RST = 6'd32;

	typedef enum logic [1:0] {
		FUNC_RESTART  = 2'd0,
		FUNC_RESTRICT = 2'd1,
		FUNC_COLLAPSE = 2'd2,
		FUNC_SCAN     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_ROWS  = 2'd0,
		REG_COLS  = 2'd1,
		REG_TILES = 2'd2,
		REG_NONE  = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_READ,
		ST_OP,
		ST_MOD,
		ST_STRIP,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	// zero counts as one, anything above hi saturates
	function automatic logic [4:0] clamp_dim(input logic [4:0] v, input int hi);
		logic [4:0] r;
		if (v == 5'd0) begin
			r = 5'd1;
		end else if (int'(v) > hi) begin
			r = 5'(hi);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [CELL_W-1:0] full_mask(input logic [5:0] tiles,
	                                              input int max_tiles);
		int         hi;
		logic [5:0] t;
		logic [CELL_W-1:0] m;
		hi = (max_tiles < CELL_W) ? max_tiles : CELL_W;
		if (tiles == 6'd0) begin
			t = 6'd1;
		end else if (int'(tiles) > hi) begin
			t = 6'(hi);
		end else begin
			t = tiles;
		end
		if (int'(t) >= CELL_W) begin
			m = '1;
		end else begin
			m = (CELL_W'(1) << t) - CELL_W'(1);
		end
		return m;
	endfunction

	function automatic logic [CNT_W-1:0] popcount(input logic [CELL_W-1:0] m);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < CELL_W; i++) begin
			n = n + CNT_W'(m[i]);
		end
		return n;
	endfunction

endpackage

>>> hw/rtl/tile_candidate_grid_core.sv
// Tile candidate grid: cell mask memory, operation sequencer, APB registers.
// Depends on tcg_pkg.
//
// Usage
//  - Command channel: a word is taken at a rising edge with start high and
//    busy low. func selects restart, restrict, collapse or scan; row/col
//    address a cell, keep_mask feeds restrict, pick feeds collapse.
//  - Result channel: done pulses for one cycle with the result word on
//    cell_mask .. all_collapsed. The receiver cannot stall; the word holds
//    only until the next result. busy drops in the same cycle done rises,
//    so a new command can be taken while the result is on the ports.
//  - APB: rows_in_use at 0x0, cols_in_use at 0x4, tiles_in_use at 0x8.
//    Write only while idle. New tile counts apply at the next restart.
// Sequencing, shaped by the one read port and one write port of the cell
// memory and the one popcount unit that the sequencer reuses:
//  - restrict: read, modify/write, result; read then result if out of range
//  - collapse: read, then modulo by repeated subtract, then one lowest bit
//    stripped per cycle; read then result if out of range
//  - scan: one cell read per cycle over rows*cols cells, drain, result
//  - restart: one cell written per cycle over all MAX_ROWS*MAX_COLS cells
// Reset: registers go to 16/16/32 and a clearing pass writes the full mask
// to all MAX_ROWS*MAX_COLS cells; busy stays high meanwhile.
module tile_candidate_grid_core #(
	parameter int MAX_ROWS  = tcg_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS  = tcg_pkg::MAX_COLS_DEF,
	parameter int MAX_TILES = tcg_pkg::MAX_TILES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// command channel
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                func,
	input  logic [3:0]                row,
	input  logic [3:0]                col,
	input  logic [31:0]               keep_mask,
	input  logic [4:0]                pick,
	// result channel
	output logic                      done,
	output logic [31:0]               cell_mask,
	output logic                      changed,
	output logic                      emptied,
	output logic                      min_found,
	output logic [3:0]                min_row,
	output logic [3:0]                min_col,
	output logic                      all_collapsed,
	// APB configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [tcg_pkg::CFG_AW-1:0] paddr,
	input  logic [tcg_pkg::CFG_W-1:0] pwdata,
	output logic [tcg_pkg::CFG_W-1:0] prdata,
	output logic                      pready
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam int CW    = tcg_pkg::CELL_W;
	localparam int NW    = tcg_pkg::CNT_W;

	// ---------------- configuration registers ----------------
	logic [4:0] rows_q;
	logic [4:0] cols_q;
	logic [5:0] tiles_q;
	logic       cfg_wr;
	tcg_pkg::reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = tcg_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= tcg_pkg::ROWS_RST;
			cols_q  <= tcg_pkg::COLS_RST;
			tiles_q <= tcg_pkg::TILES_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				tcg_pkg::REG_ROWS:  rows_q  <= pwdata[4:0];
				tcg_pkg::REG_COLS:  cols_q  <= pwdata[4:0];
				tcg_pkg::REG_TILES: tiles_q <= pwdata[5:0];
				default:            ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			tcg_pkg::REG_ROWS:  prdata = tcg_pkg::CFG_W'(rows_q);
			tcg_pkg::REG_COLS:  prdata = tcg_pkg::CFG_W'(cols_q);
			tcg_pkg::REG_TILES: prdata = tcg_pkg::CFG_W'(tiles_q);
			default:            prdata = '0;
		endcase
	end

	logic [4:0]    rows_eff;
	logic [4:0]    cols_eff;
	logic [CW-1:0] fill_mask;
	logic [CW-1:0] rst_mask;

	assign rows_eff  = tcg_pkg::clamp_dim(rows_q, MAX_ROWS);
	assign cols_eff  = tcg_pkg::clamp_dim(cols_q, MAX_COLS);
	assign fill_mask = tcg_pkg::full_mask(tiles_q, MAX_TILES);
	assign rst_mask  = tcg_pkg::full_mask(tcg_pkg::TILES_RST, MAX_TILES);

	// ---------------- cell memory ----------------
	logic [CW-1:0] cell_mem [DEPTH];
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [CW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [CW-1:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= cell_mem[mem_raddr];
	end

	// ---------------- command and working registers ----------------
	tcg_pkg::state_t state_q, state_d;
	tcg_pkg::func_t  func_q;
	logic [3:0]      row_q;
	logic [3:0]      col_q;
	logic [CW-1:0]   keep_q;
	logic [4:0]      pick_q;

	logic [AW-1:0]   ptr_q;       // fill / clear sweep address
	logic [4:0]      scan_r_q;
	logic [4:0]      scan_c_q;
	logic            cmp_v_s1;
	logic [4:0]      cmp_r_s1;
	logic [4:0]      cmp_c_s1;
	logic [NW-1:0]   best_q;
	logic            found_q;
	logic [4:0]      min_r_q;
	logic [4:0]      min_c_q;
	logic [CW-1:0]   m_q;         // collapse working mask
	logic [NW-1:0]   cnt_q;
	logic [4:0]      k_q;

	logic            accept;
	logic            in_range;
	logic [AW-1:0]   cell_addr;
	logic [AW-1:0]   scan_addr;
	logic            scan_last;
	logic [NW-1:0]   rd_cnt;      // the shared popcount unit
	logic            k_ge_cnt;

	assign busy      = (state_q != tcg_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign in_range  = ({1'b0, row_q} < rows_eff) && ({1'b0, col_q} < cols_eff);
	assign cell_addr = AW'(32'(row_q) * MAX_COLS + 32'(col_q));
	assign scan_addr = AW'(32'(scan_r_q) * MAX_COLS + 32'(scan_c_q));
	assign scan_last = (scan_r_q == rows_eff - 5'd1) && (scan_c_q == cols_eff - 5'd1);
	assign rd_cnt    = tcg_pkg::popcount(rdata_s1);
	assign k_ge_cnt  = ({1'b0, k_q} >= cnt_q);

	// result word staged for the done strobe
	logic          fin;
	logic [CW-1:0] res_mask;
	logic          res_changed;
	logic          res_emptied;
	logic          res_scan;
	logic [CW-1:0] new_mask;
	logic [CW-1:0] one_hot;

	assign new_mask = rdata_s1 & keep_q;
	assign one_hot  = m_q & (~m_q + CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcg_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		mem_we      = 1'b0;
		mem_waddr   = cell_addr;
		mem_wdata   = new_mask;
		mem_raddr   = cell_addr;
		fin         = 1'b0;
		res_mask    = '0;
		res_changed = 1'b0;
		res_emptied = 1'b0;
		res_scan    = 1'b0;
		unique case (state_q)
			tcg_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = rst_mask;
				if (ptr_q == LAST_ADDR) begin
					state_d = tcg_pkg::ST_IDLE;
				end
			end
			tcg_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (tcg_pkg::func_t'(func))
						tcg_pkg::FUNC_RESTART: state_d = tcg_pkg::ST_FILL;
						tcg_pkg::FUNC_SCAN:    state_d = tcg_pkg::ST_SCAN;
						default:               state_d = tcg_pkg::ST_READ;
					endcase
				end
			end
			tcg_pkg::ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = fill_mask;
				if (ptr_q == LAST_ADDR) begin
					fin      = 1'b1;
					res_mask = in_range ? fill_mask : '0;
					state_d  = tcg_pkg::ST_IDLE;
				end
			end
			tcg_pkg::ST_READ: begin
				if (in_range) begin
					state_d = tcg_pkg::ST_OP;
				end else begin
					fin     = 1'b1;
					state_d = tcg_pkg::ST_IDLE;
				end
			end
			tcg_pkg::ST_OP: begin
				if (func_q == tcg_pkg::FUNC_RESTRICT) begin
					mem_we      = 1'b1;
					fin         = 1'b1;
					res_mask    = new_mask;
					res_changed = (new_mask != rdata_s1);
					res_emptied = (new_mask == '0);
					state_d     = tcg_pkg::ST_IDLE;
				end else if (rd_cnt <= NW'(1)) begin
					fin         = 1'b1;
					res_mask    = rdata_s1;
					res_emptied = (rdata_s1 == '0);
					state_d     = tcg_pkg::ST_IDLE;
				end else begin
					state_d = tcg_pkg::ST_MOD;
				end
			end
			tcg_pkg::ST_MOD: begin
				if (!k_ge_cnt) begin
					state_d = tcg_pkg::ST_STRIP;
				end
			end
			tcg_pkg::ST_STRIP: begin
				if (k_q == 5'd0) begin
					mem_we      = 1'b1;
					mem_wdata   = one_hot;
					fin         = 1'b1;
					res_mask    = one_hot;
					res_changed = 1'b1;
					state_d     = tcg_pkg::ST_IDLE;
				end
			end
			tcg_pkg::ST_SCAN: begin
				mem_raddr = scan_addr;
				if (scan_last) begin
					state_d = tcg_pkg::ST_DRAIN;
				end
			end
			tcg_pkg::ST_DRAIN: begin
				// last compare retires; fetch the addressed cell
				state_d = tcg_pkg::ST_FIN;
			end
			tcg_pkg::ST_FIN: begin
				fin         = 1'b1;
				res_scan    = 1'b1;
				res_mask    = in_range ? rdata_s1 : '0;
				res_emptied = in_range && (rdata_s1 == '0);
				state_d     = tcg_pkg::ST_IDLE;
			end
			default: state_d = tcg_pkg::ST_IDLE;
		endcase
	end

	// sweep pointer and scan pipeline valid are control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			cmp_v_s1 <= 1'b0;
			done     <= 1'b0;
		end else begin
			cmp_v_s1 <= (state_q == tcg_pkg::ST_SCAN);
			done     <= fin;
			if (accept) begin
				ptr_q <= '0;
			end else if (state_q == tcg_pkg::ST_CLEAR || state_q == tcg_pkg::ST_FILL) begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_r_s1 <= scan_r_q;
		cmp_c_s1 <= scan_c_q;
		if (accept) begin
			func_q   <= tcg_pkg::func_t'(func);
			row_q    <= row;
			col_q    <= col;
			keep_q   <= keep_mask;
			pick_q   <= pick;
			scan_r_q <= '0;
			scan_c_q <= '0;
			best_q   <= '1;
			found_q  <= 1'b0;
			min_r_q  <= '0;
			min_c_q  <= '0;
		end else begin
			if (state_q == tcg_pkg::ST_SCAN) begin
				if (scan_c_q == cols_eff - 5'd1) begin
					scan_c_q <= '0;
					scan_r_q <= scan_r_q + 5'd1;
				end else begin
					scan_c_q <= scan_c_q + 5'd1;
				end
			end
			if (cmp_v_s1 && (rd_cnt > NW'(1)) && (rd_cnt < best_q)) begin
				best_q  <= rd_cnt;
				found_q <= 1'b1;
				min_r_q <= cmp_r_s1;
				min_c_q <= cmp_c_s1;
			end
		end
		unique case (state_q)
			tcg_pkg::ST_OP: begin
				m_q   <= rdata_s1;
				cnt_q <= rd_cnt;
				k_q   <= pick_q;
			end
			tcg_pkg::ST_MOD: begin
				if (k_ge_cnt) begin
					k_q <= 5'({1'b0, k_q} - cnt_q);
				end
			end
			tcg_pkg::ST_STRIP: begin
				if (k_q != 5'd0) begin
					m_q <= m_q & (m_q - CW'(1));
					k_q <= k_q - 5'd1;
				end
			end
			default: ;
		endcase
		if (fin) begin
			cell_mask     <= res_mask;
			changed       <= res_changed;
			emptied       <= res_emptied;
			min_found     <= res_scan && found_q;
			min_row       <= res_scan ? min_r_q[3:0] : 4'd0;
			min_col       <= res_scan ? min_c_q[3:0] : 4'd0;
			all_collapsed <= res_scan && !found_q;
		end
	end

endmodule

>>> tb/tb_top.sv
// Self-checking bench for tile_candidate_grid_core: command/result words plus APB registers.
// A scoreboard class predicts every result word. Depends on tcg_pkg and the core RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_ROWS   = tcg_pkg::MAX_ROWS_DEF;
	localparam int GRID_COLS   = tcg_pkg::MAX_COLS_DEF;
	localparam int TILE_MAX    = (tcg_pkg::MAX_TILES_DEF < 32) ? tcg_pkg::MAX_TILES_DEF : 32;
	// restart walks every cell; allow that plus the longest sender gap many times over
	localparam int QUIET_LIMIT = 5000;
	localparam int END_WAIT    = GRID_ROWS * GRID_COLS + 50;
	localparam int GAP_MAX     = 20;
	localparam int SET_WORDS   = 32;

	// one result word, in port order
	typedef struct packed {
		logic [31:0] cell_mask;
		logic        changed;
		logic        emptied;
		logic        min_found;
		logic [3:0]  min_row;
		logic [3:0]  min_col;
		logic        all_collapsed;
	} grid_word_t;

	// Shadow of the grid and registers; turns each accepted command into the
	// result word it must produce and checks the words that come back.
	class grid_scoreboard;
		logic [31:0] cells [GRID_ROWS*GRID_COLS];
		logic [4:0]  rows_reg;
		logic [4:0]  cols_reg;
		logic [5:0]  tiles_reg;
		grid_word_t  due_words [$];
		int          errors;
		// outcome of the latest scan, used to steer collapse sequences
		logic        last_found;
		logic [3:0]  last_row;
		logic [3:0]  last_col;

		function new();
			rows_reg   = tcg_pkg::ROWS_RST;
			cols_reg   = tcg_pkg::COLS_RST;
			tiles_reg  = tcg_pkg::TILES_RST;
			errors     = 0;
			last_found = 1'b0;
			last_row   = '0;
			last_col   = '0;
			refill();
		endfunction

		function int dim_used(logic [4:0] v, int hi);
			if (v == 5'd0)
				return 1;
			return (int'(v) > hi) ? hi : int'(v);
		endfunction

		function logic [31:0] fill_pattern();
			int t;
			t = (tiles_reg == 6'd0) ? 1 : int'(tiles_reg);
			if (t > TILE_MAX)
				t = TILE_MAX;
			if (t >= 32)
				return '1;
			return (32'h1 << t) - 32'h1;
		endfunction

		function int ones(logic [31:0] m);
			int n;
			n = 0;
			for (int i = 0; i < 32; i++)
				n += int'(m[i]);
			return n;
		endfunction

		function void refill();
			logic [31:0] m;
			m = fill_pattern();
			foreach (cells[i])
				cells[i] = m;
		endfunction

		function void set_reg(tcg_pkg::reg_idx_t i, logic [31:0] d);
			case (i)
				tcg_pkg::REG_ROWS:  rows_reg  = d[4:0];
				tcg_pkg::REG_COLS:  cols_reg  = d[4:0];
				tcg_pkg::REG_TILES: tiles_reg = d[5:0];
				default:            ;
			endcase
		endfunction

		function logic [31:0] reg_value(tcg_pkg::reg_idx_t i);
			case (i)
				tcg_pkg::REG_ROWS:  return 32'(rows_reg);
				tcg_pkg::REG_COLS:  return 32'(cols_reg);
				tcg_pkg::REG_TILES: return 32'(tiles_reg);
				default:            return '0;
			endcase
		endfunction

		function void note_command(tcg_pkg::func_t f, logic [3:0] r, logic [3:0] c,
		                           logic [31:0] keep, logic [4:0] pk);
			grid_word_t  w;
			int          rows, cols, idx, cnt, k, best, n;
			logic        hit;
			logic [31:0] old, m;
			w    = '0;
			rows = dim_used(rows_reg, GRID_ROWS);
			cols = dim_used(cols_reg, GRID_COLS);
			hit  = (int'(r) < rows) && (int'(c) < cols);
			idx  = int'(r) * GRID_COLS + int'(c);
			case (f)
				tcg_pkg::FUNC_RESTART: refill();
				tcg_pkg::FUNC_RESTRICT: if (hit) begin
					old        = cells[idx];
					cells[idx] = old & keep;
					w.changed  = (cells[idx] != old);
				end
				tcg_pkg::FUNC_COLLAPSE: if (hit) begin
					old = cells[idx];
					cnt = ones(old);
					if (cnt > 1) begin
						// drop the k lowest candidates, then keep the lowest left
						k = int'(pk) % cnt;
						m = old;
						repeat (k) m = m & (m - 32'h1);
						cells[idx] = m & (~m + 32'h1);
						w.changed  = 1'b1;
					end
				end
				tcg_pkg::FUNC_SCAN: begin
					best = 33;
					for (int rr = 0; rr < rows; rr++) begin
						for (int cc = 0; cc < cols; cc++) begin
							n = ones(cells[rr*GRID_COLS+cc]);
							if (n > 1 && n < best) begin
								best        = n;
								w.min_found = 1'b1;
								w.min_row   = 4'(rr);
								w.min_col   = 4'(cc);
							end
						end
					end
					w.all_collapsed = !w.min_found;
					last_found      = w.min_found;
					last_row        = w.min_row;
					last_col        = w.min_col;
				end
			endcase
			if (hit) begin
				w.cell_mask = cells[idx];
				w.emptied   = (cells[idx] == 32'h0);
			end
			due_words.insert(due_words.size(), w);
		endfunction

		function void same_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %h actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_word(grid_word_t got);
			grid_word_t want;
			if (due_words.size() == 0) begin
				$display("%0t: result word with none outstanding, expected none actual %h",
				         $time, got);
				errors++;
				return;
			end
			want = due_words.pop_front();
			same_field("cell_mask", want.cell_mask, got.cell_mask);
			same_field("changed", 32'(want.changed), 32'(got.changed));
			same_field("emptied", 32'(want.emptied), 32'(got.emptied));
			same_field("min_found", 32'(want.min_found), 32'(got.min_found));
			same_field("min_row", 32'(want.min_row), 32'(got.min_row));
			same_field("min_col", 32'(want.min_col), 32'(got.min_col));
			same_field("all_collapsed", 32'(want.all_collapsed), 32'(got.all_collapsed));
		endfunction
	endclass

	// ---------------------------------------------------------------- DUT pins
	// everything the bench drives has a known value from time zero
	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       start     = 1'b0;
	tcg_pkg::func_t             func      = tcg_pkg::FUNC_RESTART;
	logic [3:0]                 row       = '0;
	logic [3:0]                 col       = '0;
	logic [31:0]                keep_mask = '0;
	logic [4:0]                 pick      = '0;
	logic                       psel      = 1'b0;
	logic                       penable   = 1'b0;
	logic                       pwrite    = 1'b0;
	logic [tcg_pkg::CFG_AW-1:0] paddr     = '0;
	logic [tcg_pkg::CFG_W-1:0]  pwdata    = '0;

	logic                       busy;
	logic                       done;
	logic [31:0]                cell_mask;
	logic                       changed;
	logic                       emptied;
	logic                       min_found;
	logic [3:0]                 min_row;
	logic [3:0]                 min_col;
	logic                       all_collapsed;
	logic [tcg_pkg::CFG_W-1:0]  prdata;
	logic                       pready;

	grid_scoreboard sb = new();

	// driver-side view of the setting, only used to aim addresses and masks
	int rows_on    = 16;
	int cols_on    = 16;
	int tiles_on   = 32;
	int idle_pct   = 0;
	int words_sent = 0;
	int quiet      = 0;

	tile_candidate_grid_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.row          (row),
		.col          (col),
		.keep_mask    (keep_mask),
		.pick         (pick),
		.done         (done),
		.cell_mask    (cell_mask),
		.changed      (changed),
		.emptied      (emptied),
		.min_found    (min_found),
		.min_row      (min_row),
		.min_col      (min_col),
		.all_collapsed(all_collapsed),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #10 clk = ~clk;

	// Result side: done is a one-cycle strobe that cannot be held off, so the
	// word is taken at the edge ending that cycle. Sampling right after the
	// edge sees the pre-edge values since the core updates with NBAs.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_word({cell_mask, changed, emptied, min_found, min_row, min_col,
			               all_collapsed});
	end

	// Watchdog: any command, result or APB access counts as progress. Reset and
	// the clearing pass after it sit well inside the limit.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("%0t: watchdog, %0d cycles without progress", $time, quiet);
			$display("tb_top: FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// ------------------------------------------------------------ command side
	// start stays high from one word to the next unless a gap is inserted, so
	// it never sees a low and a high NBA in the same step.
	task automatic send_word(tcg_pkg::func_t f, logic [3:0] r, logic [3:0] c,
	                         logic [31:0] keep, logic [4:0] pk);
		int gap;
		gap = 0;
		while (gap < GAP_MAX && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		func      <= f;
		row       <= r;
		col       <= c;
		keep_mask <= keep;
		pick      <= pk;
		@(posedge clk);
		while (busy) @(posedge clk);
		// taken at this edge: predict right away so later steering sees it
		sb.note_command(f, r, c, keep, pk);
		words_sent++;
	endtask

	// drop start, let every outstanding word come back, then settle
	task automatic wait_idle(int extra);
		start <= 1'b0;
		while (sb.due_words.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- APB side
	// setup + access, then one idle cycle so back-to-back transfers never
	// lower and raise psel in one step
	task automatic reg_write(tcg_pkg::reg_idx_t i, logic [31:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {i, 2'b00};
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(i, d);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read(tcg_pkg::reg_idx_t i);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {i, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== sb.reg_value(i)) begin
			$display("%0t: register %0d read expected %h actual %h", $time, i,
			         sb.reg_value(i), prdata);
			sb.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Program all three registers (random junk above the field bits), read
	// them back, and refresh the driver's notion of the grid size.
	task automatic apply_setting(logic [4:0] r, logic [4:0] c, logic [5:0] t);
		wait_idle(8);
		reg_write(tcg_pkg::REG_ROWS, ($urandom & ~32'h1F) | 32'(r));
		reg_write(tcg_pkg::REG_COLS, ($urandom & ~32'h1F) | 32'(c));
		reg_write(tcg_pkg::REG_TILES, ($urandom & ~32'h3F) | 32'(t));
		reg_read(tcg_pkg::REG_ROWS);
		reg_read(tcg_pkg::REG_COLS);
		reg_read(tcg_pkg::REG_TILES);
		rows_on  = sb.dim_used(r, GRID_ROWS);
		cols_on  = sb.dim_used(c, GRID_COLS);
		tiles_on = (t == 6'd0) ? 1 : ((int'(t) > TILE_MAX) ? TILE_MAX : int'(t));
	endtask

	// ------------------------------------------------------- random stimulus
	function automatic logic [3:0] aim_row();
		return ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(rows_on - 1));
	endfunction

	function automatic logic [3:0] aim_col();
		return ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(cols_on - 1));
	endfunction

	// mostly knock out one or two live tiles so cells shrink gradually
	function automatic logic [31:0] keep_choice();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50)
			return ~(32'h1 << $urandom_range(tiles_on - 1));
		if (sel < 65)
			return ~((32'h1 << $urandom_range(tiles_on - 1)) | (32'h1 << $urandom_range(31)));
		if (sel < 80)
			return $urandom;
		if (sel < 90)
			return 32'h0;
		return '1;
	endfunction

	// One stretch under a fixed setting. The bulk is collapse-solver style:
	// scan, collapse the cell it names, prune cells; the rest is raw noise.
	task automatic run_setting(int n);
		int stop, sel;
		stop = words_sent + n;
		if ($urandom_range(7) != 0)
			send_word(tcg_pkg::FUNC_RESTART, 4'($urandom), 4'($urandom), $urandom,
			          5'($urandom));
		while (words_sent < stop) begin
			sel = $urandom_range(99);
			if (sel < 25) begin
				send_word(tcg_pkg::FUNC_SCAN, aim_row(), aim_col(), $urandom, 5'($urandom));
				if (sb.last_found)
					send_word(tcg_pkg::FUNC_COLLAPSE, sb.last_row, sb.last_col, $urandom,
					          5'($urandom));
				else if ($urandom_range(1) == 0)
					send_word(tcg_pkg::FUNC_RESTART, aim_row(), aim_col(), $urandom,
					          5'($urandom));
			end else if (sel < 65) begin
				send_word(tcg_pkg::FUNC_RESTRICT, aim_row(), aim_col(), keep_choice(),
				          5'($urandom));
			end else if (sel < 85) begin
				send_word(tcg_pkg::FUNC_COLLAPSE, aim_row(), aim_col(), $urandom,
				          5'($urandom));
			end else begin
				send_word(tcg_pkg::func_t'($urandom_range(3)), 4'($urandom), 4'($urandom),
				          $urandom, 5'($urandom));
			end
		end
	endtask

	// ------------------------------------------------------------------ main
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset grid, full-width masks, corner cells
		send_word(tcg_pkg::FUNC_SCAN, 4'd0, 4'd0, 32'h0, 5'd0);
		send_word(tcg_pkg::FUNC_RESTRICT, 4'd0, 4'd0, 32'hFFFF_FFFF, 5'd0);  // no change
		send_word(tcg_pkg::FUNC_RESTRICT, 4'd15, 4'd15, 32'h0, 5'd31);       // cell emptied
		send_word(tcg_pkg::FUNC_RESTRICT, 4'd3, 4'd4, 32'hA5A5_A5A5, 5'd0);
		send_word(tcg_pkg::FUNC_COLLAPSE, 4'd3, 4'd4, 32'h0, 5'd31);    // pick wraps mod 16
		send_word(tcg_pkg::FUNC_COLLAPSE, 4'd3, 4'd4, 32'h0, 5'd0);     // single candidate left
		send_word(tcg_pkg::FUNC_COLLAPSE, 4'd15, 4'd15, 32'h0, 5'd5);   // empty cell
		send_word(tcg_pkg::FUNC_COLLAPSE, 4'd1, 4'd1, 32'h0, 5'd31);    // top tile kept
		send_word(tcg_pkg::FUNC_COLLAPSE, 4'd2, 4'd2, 32'h0, 5'd0);     // bottom tile kept
		send_word(tcg_pkg::FUNC_SCAN, 4'd15, 4'd15, 32'hFFFF_FFFF, 5'd31);
		send_word(tcg_pkg::FUNC_RESTART, 4'd7, 4'd9, 32'h0, 5'd0);

		// shrink the grid without a restart: cells keep tiles above the new count
		apply_setting(5'd3, 5'd2, 6'd5);
		send_word(tcg_pkg::FUNC_RESTRICT, 4'd3, 4'd0, 32'h0, 5'd0);     // row out of range
		send_word(tcg_pkg::FUNC_RESTRICT, 4'd0, 4'd2, 32'h0, 5'd0);     // col out of range
		send_word(tcg_pkg::FUNC_COLLAPSE, 4'd15, 4'd15, 32'h0, 5'd3);
		send_word(tcg_pkg::FUNC_SCAN, 4'd2, 4'd1, 32'h0, 5'd0);
		send_word(tcg_pkg::FUNC_RESTART, 4'd0, 4'd0, 32'h0, 5'd0);
		send_word(tcg_pkg::FUNC_SCAN, 4'd15, 4'd15, 32'h0, 5'd0);       // address out of range: cell word zero
		send_word(tcg_pkg::FUNC_COLLAPSE, 4'd0, 4'd0, 32'h0, 5'd4);

		// zero register values count as one: single cell, single tile
		apply_setting(5'd0, 5'd0, 6'd0);
		send_word(tcg_pkg::FUNC_RESTART, 4'd0, 4'd0, 32'h0, 5'd0);
		send_word(tcg_pkg::FUNC_SCAN, 4'd0, 4'd0, 32'h0, 5'd0);         // grid fully collapsed

		// oversized values saturate; a write past the last register is dropped
		apply_setting(5'd31, 5'd17, 6'd63);
		reg_write(tcg_pkg::REG_NONE, $urandom);
		send_word(tcg_pkg::FUNC_RESTART, 4'd15, 4'd15, 32'h0, 5'd0);
		send_word(tcg_pkg::FUNC_SCAN, 4'd0, 4'd0, 32'h0, 5'd0);
		send_word(tcg_pkg::FUNC_RESTRICT, 4'd15, 4'd0, 32'h8000_0001, 5'd0);

		// random: three sender idle profiles, each through extremes and
		// random settings
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 19 : ((ph == 1) ? 51 : 0);
			apply_setting(5'd16, 5'd16, 6'd32);
			run_setting(SET_WORDS);
			apply_setting(5'd1, 5'd1, 6'd1);
			run_setting(SET_WORDS);
			apply_setting(5'($urandom_range(5, 1)), 5'($urandom_range(5, 1)),
			              6'($urandom_range(6, 2)));
			run_setting(SET_WORDS);
			apply_setting(5'($urandom), 5'($urandom), 6'($urandom));
			run_setting(SET_WORDS);
			apply_setting(5'($urandom_range(10, 2)), 5'($urandom_range(10, 2)),
			              6'($urandom_range(32, 2)));
			run_setting(SET_WORDS);
		end

		// drain, then give stray words a chance to show up
		start <= 1'b0;
		while (sb.due_words.size() != 0) @(posedge clk);
		repeat (END_WAIT) @(posedge clk);
		if (sb.due_words.size() != 0) begin
			$display("%0t: %0d result words never arrived", $time, sb.due_words.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
